>>> rtl/core/tqs_pkg.sv
// shared widths, defaults and ternary codes for the ternary quantiser
`default_nettype none

package tqs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int DELTA_W          = 15;
    localparam int SUM_W            = 32;
    localparam int CNT_W            = 17;
    localparam int SCALE_W          = 16;
    localparam int TERN_W           = 2;

    typedef logic signed [TERN_W-1:0] t_tern;

    localparam t_tern TERN_POS  = 2'sb01;
    localparam t_tern TERN_ZERO = 2'sb00;
    localparam t_tern TERN_NEG  = 2'sb11;

endpackage

`default_nettype wire

>>> rtl/core/tqs_in_if.sv
// input channel: one weight word per handshake
`default_nettype none

interface tqs_in_if
    import tqs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] weight_sample;
    logic                           is_last;

    modport source (output valid, output weight_sample, output is_last, input ready);
    modport sink   (input valid, input weight_sample, input is_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tqs_out_if.sv
// output channel: one ternary result word per handshake
`default_nettype none

interface tqs_out_if
    import tqs_pkg::*;
;
    logic               valid;
    logic               ready;
    t_tern              ternary_value;
    logic               scale_valid;
    logic [SCALE_W-1:0] scale_value;

    modport source (output valid, output ternary_value, output scale_valid,
                    output scale_value, input ready);
    modport sink   (input valid, input ternary_value, input scale_valid,
                    input scale_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ternary_quantizer_with_scale.sv
// Ternary weight quantiser. Each weight word maps to +1, 0 or -1 against
// the programmed threshold; magnitudes of weights that map to nonzero are
// summed and counted. A weight that is not marked last has its result go
// straight to the output register. For the last weight of a block the
// word is first accumulated, then a one-bit-per-cycle restoring divider
// (sum over count) runs, reusing the accumulator registers, and then the
// result carrying the scale is loaded once the output register is free. No
// word is taken while the divider runs. Input is taken while a result waits,
// as long as the output register is being emptied in the same cycle or is
// already empty. Sum and count saturate rather than wrap; the scale saturates at 65535.
`default_nettype none

module ternary_quantizer_with_scale
    import tqs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_wr_en,
    input  wire  [DELTA_W-1:0] i_cfg_wr_data,
    tqs_in_if.sink             i_wt,
    tqs_out_if.source          o_res
);

    localparam int CMP_W  = (SAMPLE_WIDTH > DELTA_W) ? SAMPLE_WIDTH : DELTA_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [DELTA_W-1:0]   r_delta;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [STEP_W-1:0]    r_step;
    t_tern                r_tern_hold;
    logic                 r_out_valid;
    t_tern                r_out_tern;
    logic                 r_out_sv;
    logic [SCALE_W-1:0]   r_out_scale;

    logic                    out_free;
    logic                    out_load;
    logic                    in_ready;
    logic                    in_take;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic                    hit;
    t_tern                   tern;
    logic [SUM_W:0]          sum_add;
    logic [SUM_W-1:0]        n_sum;
    logic [CNT_W-1:0]        n_cnt;
    logic [CNT_W:0]          trial;
    logic                    trial_ge;
    logic [SCALE_W-1:0]      scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
        end else if (i_cfg_wr_en) begin
            r_delta <= i_cfg_wr_data;
        end
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign in_ready = (r_state == ST_IDLE) && out_free;
    assign in_take  = i_wt.valid && in_ready;
    assign out_load = (in_take && !i_wt.is_last) || ((r_state == ST_DONE) && out_free);

    // most negative weight gives 2^(w-1), exact as unsigned
    always_comb begin
        mag = i_wt.weight_sample[SAMPLE_WIDTH-1] ? (~i_wt.weight_sample + 1'b1)
                                                 : i_wt.weight_sample;
        hit  = CMP_W'(mag) > CMP_W'(r_delta);
        tern = !hit ? TERN_ZERO
             : (i_wt.weight_sample[SAMPLE_WIDTH-1] ? TERN_NEG : TERN_POS);
        sum_add = {1'b0, r_sum} + (SUM_W+1)'(mag);
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        if (hit) begin
            n_sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
        end
    end

    // restoring divider step: remainder stays below a nonzero divisor
    always_comb begin
        trial    = {r_rem, r_sum[SUM_W-1]};
        trial_ge = trial >= {1'b0, r_cnt};
        scale    = '0;
        if (r_cnt != '0) begin
            scale = (r_sum[SUM_W-1:SCALE_W] != '0) ? '1 : r_sum[SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_sum <= n_sum;
                        r_cnt <= n_cnt;
                        if (i_wt.is_last) begin
                            r_tern_hold <= tern;
                            r_rem       <= '0;
                            r_step      <= '0;
                            r_state     <= ST_DIV;
                        end else begin
                            r_out_tern  <= tern;
                            r_out_sv    <= 1'b0;
                            r_out_scale <= '0;
                        end
                    end
                end
                ST_DIV: begin
                    // quotient bits shift into the low end of the sum register
                    r_sum  <= {r_sum[SUM_W-2:0], trial_ge};
                    r_rem  <= trial_ge ? CNT_W'(trial - {1'b0, r_cnt}) : trial[CNT_W-1:0];
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_tern  <= r_tern_hold;
                        r_out_sv    <= 1'b1;
                        r_out_scale <= scale;
                        r_sum       <= '0;
                        r_cnt       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_wt.ready          = in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.ternary_value = r_out_tern;
    assign o_res.scale_valid   = r_out_sv;
    assign o_res.scale_value   = r_out_scale;

endmodule

`default_nettype wire
